/* rtl/ppsf_pkg.sv */
// Package for the pulse-period speed filter: widths, register indexes,
// and the structs shared by the sequencer, the arithmetic unit and the top level.
// No dependencies.
package ppsf_pkg;

  localparam int FRAC_BITS = 8;
  localparam int SCALE     = 1 << FRAC_BITS;

  localparam int SPEED_W   = 20;
  localparam int NUM_W     = 32;
  localparam int ALPHA_W   = 9;
  localparam int MININT_W  = 16;
  localparam int TICK_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 32;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // Saturated alpha never exceeds SCALE, so it fits in FRAC_BITS + 1 bits.
  localparam int MUL_W     = FRAC_BITS + 1;
  localparam int MUL_STEPS = MUL_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int BLEND_W   = SPEED_W + FRAC_BITS + 2;
  localparam int ALU_W     = (BLEND_W > NUM_W + 2) ? BLEND_W : NUM_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0]    speed_num;
    logic [ALPHA_W-1:0]  alpha;
    logic [MININT_W-1:0] min_int;
    logic [TICK_W-1:0]   timeout;
  } cfg_t;

  typedef struct packed {
    logic [ALU_W-1:0] op_a;
    logic [ALU_W-1:0] op_b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

endpackage

/* rtl/ppsf_alu.sv */
// Shared add/subtract unit used for every divide and multiply step.
// Depends on ppsf_pkg for the request and response structs.
module ppsf_alu
  import ppsf_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W-1:0] op_b_eff;
  logic [ALU_W:0]   total;

  // Subtraction is a plus the inverted b plus one; carry out means no borrow.
  assign op_b_eff = req.sub ? ~req.op_b : req.op_b;
  assign total    = {1'b0, req.op_a} + {1'b0, op_b_eff} + {{ALU_W{1'b0}}, req.sub};
  assign rsp.sum   = total[ALU_W-1:0];
  assign rsp.carry = total[ALU_W];

endmodule

/* rtl/ppsf_seq.sv */
// Sequencer of the speed filter: tick state, restoring divide, shift-add blend,
// timeout check and the output register. Uses ppsf_alu through ppsf_pkg structs.
module ppsf_seq
  import ppsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_sensor_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SPEED_W-1:0] out_speed_q8,
  output logic               out_speed_updated,
  output logic               out_stopped,
  output logic [TICK_W-1:0]  out_pulse_count,
  output alu_req_t           alu_req,
  input  alu_rsp_t           alu_rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic                 level_r, level_nxt;
  logic                 last_level_r, last_level_nxt;
  logic                 seen_r, seen_nxt;
  logic [TICK_W-1:0]    ticks_r, ticks_nxt;
  logic [TICK_W-1:0]    edge_cnt_r, edge_cnt_nxt;
  logic [SPEED_W-1:0]   filt_r, filt_nxt;
  logic                 upd_r, upd_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     div_r, div_nxt;
  logic [NUM_W-1:0]     q_r, q_nxt;
  logic [NUM_W-1:0]     rem_r, rem_nxt;
  logic [ALU_W-1:0]     acc_r, acc_nxt;
  logic [ALU_W-1:0]     mcand_r, mcand_nxt;
  logic [MUL_W-1:0]     mplier_r, mplier_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]   out_speed_r, out_speed_nxt;
  logic                 out_upd_r, out_upd_nxt;
  logic                 out_stop_r, out_stop_nxt;
  logic [TICK_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic                 in_xfer;
  logic [MUL_W-1:0]     alpha_sat;
  logic [SPEED_W-1:0]   raw_sat;
  logic [ALU_W-FRAC_BITS-1:0] blend_sh;
  logic [SPEED_W-1:0]   blend_sat;
  logic [SPEED_W-1:0]   filt_new;
  logic                 timed_out;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign alpha_sat = ({{(ALU_W-ALPHA_W){1'b0}}, cfg.alpha} > ALU_W'(SCALE)) ?
                     MUL_W'(SCALE) : MUL_W'(cfg.alpha);
  assign raw_sat   = (q_r > NUM_W'(SPEED_MAX)) ? SPEED_MAX : q_r[SPEED_W-1:0];
  assign blend_sh  = acc_r[ALU_W-1:FRAC_BITS];
  assign blend_sat = (blend_sh > (ALU_W-FRAC_BITS)'(SPEED_MAX)) ?
                     SPEED_MAX : blend_sh[SPEED_W-1:0];
  assign filt_new  = upd_r ? blend_sat : filt_r;
  assign timed_out = seen_r && (ticks_r >= cfg.timeout);

  always_comb begin
    alu_req = '0;
    case (state_r)
      ST_DIV: begin
        alu_req.op_a = ALU_W'({rem_r, q_r[NUM_W-1]});
        alu_req.op_b = ALU_W'(div_r);
        alu_req.sub  = 1'b1;
      end
      ST_MUL_OLD, ST_MUL_NEW: begin
        alu_req.op_a = acc_r;
        alu_req.op_b = mplier_r[0] ? mcand_r : '0;
        alu_req.sub  = 1'b0;
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    level_nxt      = level_r;
    last_level_nxt = last_level_r;
    seen_nxt       = seen_r;
    ticks_nxt      = ticks_r;
    edge_cnt_nxt   = edge_cnt_r;
    filt_nxt       = filt_r;
    upd_nxt        = upd_r;
    cnt_nxt        = cnt_r;
    div_nxt        = div_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    acc_nxt        = acc_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_speed_nxt  = out_speed_r;
    out_upd_nxt    = out_upd_r;
    out_stop_nxt   = out_stop_r;
    out_cnt_nxt    = out_cnt_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          level_nxt = in_sensor_level;
          if (ticks_r != '1) begin
            ticks_nxt = ticks_r + TICK_W'(1);
          end
          upd_nxt   = 1'b0;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        last_level_nxt = level_r;
        state_nxt      = ST_FIN;
        if (level_r && !last_level_r) begin
          edge_cnt_nxt = edge_cnt_r + TICK_W'(1);
          seen_nxt     = 1'b1;
          ticks_nxt    = '0;
          if (seen_r && (ticks_r > TICK_W'(cfg.min_int))) begin
            div_nxt   = ticks_r;
            q_nxt     = cfg.speed_num;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(DIV_STEPS - 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        q_nxt = {q_r[NUM_W-2:0], alu_rsp.carry};
        if (alu_rsp.carry) begin
          rem_nxt = alu_rsp.sum[NUM_W-1:0];
        end else begin
          rem_nxt = {rem_r[NUM_W-2:0], q_r[NUM_W-1]};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          acc_nxt    = ALU_W'(SCALE / 2);
          mcand_nxt  = ALU_W'(filt_r);
          mplier_nxt = MUL_W'(SCALE) - alpha_sat;
          cnt_nxt    = CNT_W'(MUL_STEPS - 1);
          state_nxt  = ST_MUL_OLD;
        end
      end
      ST_MUL_OLD: begin
        acc_nxt    = alu_rsp.sum;
        mcand_nxt  = {mcand_r[ALU_W-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          mcand_nxt  = ALU_W'(raw_sat);
          mplier_nxt = alpha_sat;
          cnt_nxt    = CNT_W'(MUL_STEPS - 1);
          state_nxt  = ST_MUL_NEW;
        end
      end
      ST_MUL_NEW: begin
        acc_nxt    = alu_rsp.sum;
        mcand_nxt  = {mcand_r[ALU_W-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // The blend result is taken here, after the last accumulate.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_upd_nxt   = upd_r;
          out_stop_nxt  = timed_out;
          out_cnt_nxt   = edge_cnt_r;
          out_speed_nxt = timed_out ? '0 : filt_new;
          filt_nxt      = timed_out ? '0 : filt_new;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (state_r == ST_MUL_NEW && cnt_r == '0) begin
      upd_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    div_r        <= div_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    acc_r        <= acc_nxt;
    mcand_r      <= mcand_nxt;
    mplier_r     <= mplier_nxt;
    cnt_r        <= cnt_nxt;
    level_r      <= level_nxt;
    out_speed_r  <= out_speed_nxt;
    out_upd_r    <= out_upd_nxt;
    out_stop_r   <= out_stop_nxt;
    out_cnt_r    <= out_cnt_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_level_r <= 1'b1;
      seen_r       <= 1'b0;
      ticks_r      <= '0;
      edge_cnt_r   <= '0;
      filt_r       <= '0;
      upd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_level_r <= last_level_nxt;
      seen_r       <= seen_nxt;
      ticks_r      <= ticks_nxt;
      edge_cnt_r   <= edge_cnt_nxt;
      upd_r        <= upd_nxt;
      out_valid_r  <= out_valid_nxt;
      filt_r       <= filt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_speed_q8      = out_speed_r;
  assign out_speed_updated = out_upd_r;
  assign out_stopped       = out_stop_r;
  assign out_pulse_count   = out_cnt_r;

endmodule

/* rtl/pulse_period_speed_filter_top.sv */
// An item without a speed update goes through the evaluate and finish states to the output
// register; one with an update also runs the 32-step restoring divide and two shift-add
// multiplies of FRAC_BITS + 1 steps each, all on one shared adder, before the finish state.
// A new item is taken only once the block is back in idle; out_stall holds it in finish.
// Reset (rst_n low, synchronous) restores the configuration defaults and clears the
// tick, pulse and filter state; no result is pending after reset.
module pulse_period_speed_filter_top
  import ppsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_sensor_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SPEED_W-1:0]   out_speed_q8,
  output logic                 out_speed_updated,
  output logic                 out_stopped,
  output logic [TICK_W-1:0]    out_pulse_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_NUM: cfg_nxt.speed_num = cfg_wdata[NUM_W-1:0];
        REG_ALPHA:     cfg_nxt.alpha     = cfg_wdata[ALPHA_W-1:0];
        REG_MIN_INT:   cfg_nxt.min_int   = cfg_wdata[MININT_W-1:0];
        REG_TIMEOUT:   cfg_nxt.timeout   = cfg_wdata[TICK_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_num <= NUM_W'(771840000);
      cfg_r.alpha     <= ALPHA_W'(51);
      cfg_r.min_int   <= MININT_W'(1000);
      cfg_r.timeout   <= TICK_W'(1500000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ppsf_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ppsf_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sensor_level   (in_sensor_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed_q8      (out_speed_q8),
    .out_speed_updated (out_speed_updated),
    .out_stopped       (out_stopped),
    .out_pulse_count   (out_pulse_count),
    .alu_req           (alu_req),
    .alu_rsp           (alu_rsp)
  );

endmodule

/* rtl/ppsf_checker.sv */
// Port-level checks of the speed filter top level, attached by bind.
// Depends on ppsf_pkg for the port widths.
module ppsf_checker
  import ppsf_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [SPEED_W-1:0]   out_speed_q8,
  input logic                 out_speed_updated,
  input logic                 out_stopped,
  input logic [TICK_W-1:0]    out_pulse_count
);

  // A stalled result stays put until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_speed_q8) &&
      $stable(out_speed_updated) && $stable(out_stopped) && $stable(out_pulse_count))
    else $error("stalled result changed");

  // A timeout always reports zero speed.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> out_speed_q8 == '0)
    else $error("stopped result with nonzero speed");

  // The block is busy in the cycle after an input transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pulse_period_speed_filter_top ppsf_checker u_ppsf_checker (.*);
